[sv/tls_client_hello_sni_extractor_macros.svh]
// Assertion helpers for the server-name extractor.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_MACROS_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define TSX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TSX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/tlssni_pkg.sv]
package tlssni_pkg;

    localparam int unsigned NAME_CAPACITY = 256;
    localparam int unsigned MIN_PAYLOAD   = 47;

    localparam logic [7:0] REC_HANDSHAKE    = 8'h16;
    localparam logic [7:0] HS_CLIENT_HELLO  = 8'h01;
    localparam logic [7:0] NAME_TYPE_HOST   = 8'h00;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [17:0] SID_LEN_OFFSET  = 18'd43;

    localparam logic [2:0] RSN_FOUND       = 3'd0;
    localparam logic [2:0] RSN_TOO_SHORT   = 3'd1;
    localparam logic [2:0] RSN_NOT_HS      = 3'd2;
    localparam logic [2:0] RSN_NOT_CH      = 3'd3;
    localparam logic [2:0] RSN_OVERRUN     = 3'd4;
    localparam logic [2:0] RSN_NO_NAME     = 3'd5;

    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  name_char;
        logic        found;
        logic [2:0]  reason;
        logic [15:0] version;
        logic [7:0]  name_length;
        logic        last_of_run;
    } t_result;

endpackage

[sv/tlssni_in_if.sv]
interface tlssni_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] packet_len;

    modport source (output valid, output data_byte, output first_byte, output packet_len,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input packet_len,
                  output ready);
endinterface

[sv/tlssni_out_if.sv]
interface tlssni_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  name_char;
    logic        found;
    logic [2:0]  reason;
    logic [15:0] version;
    logic [7:0]  name_length;
    logic        last_of_run;

    modport source (output valid, output result_kind, output name_char, output found,
                    output reason, output version, output name_length,
                    output last_of_run, input ready);
    modport sink (input valid, input result_kind, input name_char, input found,
                  input reason, input version, input name_length, input last_of_run,
                  output ready);
endinterface

[sv/tls_client_hello_sni_extractor.sv]
// TLS ClientHello server-name extractor. Payload bytes go in one per cycle, first_byte
// and packet_len marking the start of each payload; every byte is parsed in the cycle
// it is taken, so the block sustains one byte per clock while the queue has room.
// Results are registered in a 4-entry result queue and leave one per transfer: one per
// emitted host-name byte and one verdict on the final payload byte. A final byte
// that is also a name byte yields two results, so input is taken only while the
// queue has at least two free slots; with the output side always ready the input
// never stalls.
`include "tls_client_hello_sni_extractor_macros.svh"

module tls_client_hello_sni_extractor (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlssni_in_if.sink i_in,
    tlssni_out_if.source o_out
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef enum logic [4:0] {
        PH_IDLE, PH_HEADER, PH_SID_LEN, PH_CS_HI, PH_CS_LO, PH_COMP_LEN,
        PH_EXTS_HI, PH_EXTS_LO, PH_ET_HI, PH_ET_LO, PH_EL_HI, PH_EL_LO,
        PH_NAME_TYPE, PH_NL_HI, PH_NL_LO, PH_NAME_BYTES, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_plen, n_plen;
    logic [17:0] r_nfo, n_nfo;
    logic [17:0] r_area_end, n_area_end;
    logic [17:0] r_ext_end, n_ext_end;
    logic [15:0] r_ext_id, n_ext_id;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_name_rem, n_name_rem;
    logic [7:0]  r_emitted, n_emitted;
    logic [15:0] r_version, n_version;
    logic [2:0]  r_reason, n_reason;

    tlssni_pkg::t_result r_queue [QDEPTH];
    logic [QAW-1:0]      r_wr_ptr, r_rd_ptr;
    logic [QAW:0]        r_count;

    logic                take;
    logic                pop;
    logic [1:0]          push_cnt;
    tlssni_pkg::t_result push0, push1;

    function automatic t_phase f_ext_loop(input logic [17:0] nfo, input logic [17:0] aend);
        return (({1'b0, nfo} + 19'd4) <= {1'b0, aend}) ? PH_ET_HI : PH_DONE;
    endfunction

    assign i_in.ready = (r_count <= (QAW+1)'(QDEPTH - 2));
    assign take       = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    always_comb begin
        logic        active;
        logic        emit_name;
        logic        emit_verdict;
        logic [15:0] v16;
        logic [7:0]  b;
        logic [17:0] pos18;
        logic        fnd;
        logic [2:0]  why;
        tlssni_pkg::t_result name_res, verdict_res;

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_plen     = r_plen;
        n_nfo      = r_nfo;
        n_area_end = r_area_end;
        n_ext_end  = r_ext_end;
        n_ext_id   = r_ext_id;
        n_len_hi   = r_len_hi;
        n_name_rem = r_name_rem;
        n_emitted  = r_emitted;
        n_version  = r_version;
        n_reason   = r_reason;
        active       = 1'b0;
        emit_name    = 1'b0;
        emit_verdict = 1'b0;
        b            = i_in.data_byte;
        v16          = {n_len_hi, b};
        pos18        = '0;
        fnd          = 1'b0;
        why          = tlssni_pkg::RSN_FOUND;

        if (take) begin
            if (i_in.first_byte) begin
                active     = 1'b1;
                n_pos      = '0;
                n_plen     = i_in.packet_len;
                n_nfo      = '0;
                n_area_end = '0;
                n_ext_end  = '0;
                n_ext_id   = '0;
                n_len_hi   = '0;
                n_name_rem = '0;
                n_emitted  = '0;
                n_version  = '0;
                n_reason   = tlssni_pkg::RSN_FOUND;
                if (i_in.packet_len < 16'(tlssni_pkg::MIN_PAYLOAD)) begin
                    n_phase  = PH_DONE;
                    n_reason = tlssni_pkg::RSN_TOO_SHORT;
                end else begin
                    n_phase = PH_HEADER;
                end
            end else if (r_phase != PH_IDLE) begin
                active = 1'b1;
                n_pos  = r_pos + 16'd1;
            end
        end

        pos18 = {2'b00, n_pos};
        v16   = {n_len_hi, b};

        if (active) begin
            if (n_phase == PH_HEADER) begin
                if (n_pos == 16'd0 && b != tlssni_pkg::REC_HANDSHAKE) begin
                    n_phase  = PH_DONE;
                    n_reason = tlssni_pkg::RSN_NOT_HS;
                end else if (n_pos == 16'd5 && b != tlssni_pkg::HS_CLIENT_HELLO) begin
                    n_phase  = PH_DONE;
                    n_reason = tlssni_pkg::RSN_NOT_CH;
                end else if (n_pos == 16'd9) begin
                    n_version = {b, 8'h00};
                end else if (n_pos == 16'd10) begin
                    n_version = {n_version[15:8], b};
                    n_nfo     = tlssni_pkg::SID_LEN_OFFSET;
                    n_phase   = PH_SID_LEN;
                end
            end else if (pos18 == n_nfo) begin
                case (n_phase)
                    PH_SID_LEN, PH_COMP_LEN: begin
                        n_nfo   = pos18 + 18'd1 + {10'd0, b};
                        n_phase = (n_phase == PH_SID_LEN) ? PH_CS_HI : PH_EXTS_HI;
                    end
                    PH_CS_HI, PH_EXTS_HI, PH_ET_HI, PH_EL_HI, PH_NL_HI: begin
                        n_len_hi = b;
                        n_nfo    = pos18 + 18'd1;
                        n_phase  = t_phase'(n_phase + 5'd1);
                    end
                    PH_CS_LO: begin
                        n_nfo   = pos18 + 18'd1 + {2'b00, v16};
                        n_phase = PH_COMP_LEN;
                    end
                    PH_EXTS_LO: begin
                        n_nfo      = pos18 + 18'd1;
                        n_area_end = pos18 + 18'd1 + {2'b00, v16};
                        if (n_area_end > {2'b00, n_plen}) n_area_end = {2'b00, n_plen};
                        n_phase = f_ext_loop(n_nfo, n_area_end);
                        if (n_phase == PH_DONE) n_reason = tlssni_pkg::RSN_NO_NAME;
                    end
                    PH_ET_LO: begin
                        n_ext_id = v16;
                        n_nfo    = pos18 + 18'd1;
                        n_phase  = PH_EL_HI;
                    end
                    PH_EL_LO: begin
                        n_ext_end = pos18 + 18'd1 + {2'b00, v16};
                        if (n_ext_end > n_area_end) begin
                            n_phase  = PH_DONE;
                            n_reason = tlssni_pkg::RSN_OVERRUN;
                        end else if (n_ext_id == tlssni_pkg::EXT_SERVER_NAME) begin
                            if (v16 < 16'd5) begin
                                n_phase  = PH_DONE;
                                n_reason = tlssni_pkg::RSN_OVERRUN;
                            end else begin
                                // skip the two-byte server name list length
                                n_nfo   = pos18 + 18'd3;
                                n_phase = PH_NAME_TYPE;
                            end
                        end else begin
                            n_nfo   = n_ext_end;
                            n_phase = f_ext_loop(n_nfo, n_area_end);
                            if (n_phase == PH_DONE) n_reason = tlssni_pkg::RSN_NO_NAME;
                        end
                    end
                    PH_NAME_TYPE: begin
                        if (b != tlssni_pkg::NAME_TYPE_HOST) begin
                            n_nfo   = n_ext_end;
                            n_phase = f_ext_loop(n_nfo, n_area_end);
                            if (n_phase == PH_DONE) n_reason = tlssni_pkg::RSN_NO_NAME;
                        end else begin
                            n_nfo   = pos18 + 18'd1;
                            n_phase = PH_NL_HI;
                        end
                    end
                    PH_NL_LO: begin
                        if ((pos18 + 18'd1 + {2'b00, v16}) <= n_ext_end) begin
                            n_name_rem = v16;
                            n_emitted  = '0;
                            if (v16 == 16'd0) begin
                                n_phase  = PH_DONE;
                                n_reason = tlssni_pkg::RSN_FOUND;
                            end else begin
                                n_nfo   = pos18 + 18'd1;
                                n_phase = PH_NAME_BYTES;
                            end
                        end else begin
                            n_nfo   = n_ext_end;
                            n_phase = f_ext_loop(n_nfo, n_area_end);
                            if (n_phase == PH_DONE) n_reason = tlssni_pkg::RSN_NO_NAME;
                        end
                    end
                    PH_NAME_BYTES: begin
                        // bytes past the capture limit are consumed but not emitted
                        if ({1'b0, n_emitted} < 9'(tlssni_pkg::NAME_CAPACITY - 1)) begin
                            emit_name = 1'b1;
                            n_emitted = n_emitted + 8'd1;
                        end
                        n_name_rem = n_name_rem - 16'd1;
                        n_nfo      = pos18 + 18'd1;
                        if (n_name_rem == 16'd0) begin
                            n_phase  = PH_DONE;
                            n_reason = tlssni_pkg::RSN_FOUND;
                        end
                    end
                    default: ;
                endcase
            end

            if (({1'b0, n_pos} + 17'd1) >= {1'b0, n_plen}) begin
                emit_verdict = 1'b1;
                why          = (n_phase == PH_DONE) ? n_reason : tlssni_pkg::RSN_OVERRUN;
                fnd          = (why == tlssni_pkg::RSN_FOUND);
                n_phase      = PH_IDLE;
            end
        end

        name_res             = '0;
        name_res.result_kind = tlssni_pkg::KIND_NAME;
        name_res.name_char   = b;
        name_res.last_of_run = !emit_verdict;

        verdict_res             = '0;
        verdict_res.result_kind = tlssni_pkg::KIND_VERDICT;
        verdict_res.found       = fnd;
        verdict_res.reason      = why;
        verdict_res.version     = n_version;
        verdict_res.name_length = fnd ? n_emitted : 8'd0;
        verdict_res.last_of_run = 1'b1;

        push0    = emit_name ? name_res : verdict_res;
        push1    = verdict_res;
        push_cnt = {1'b0, emit_name} + {1'b0, emit_verdict};
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) r_queue[r_wr_ptr] <= push0;
        if (push_cnt == 2'd2) r_queue[r_wr_ptr + QAW'(1)] <= push1;

        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_plen     <= '0;
            r_nfo      <= '0;
            r_area_end <= '0;
            r_ext_end  <= '0;
            r_ext_id   <= '0;
            r_len_hi   <= '0;
            r_name_rem <= '0;
            r_emitted  <= '0;
            r_version  <= '0;
            r_reason   <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_plen     <= n_plen;
            r_nfo      <= n_nfo;
            r_area_end <= n_area_end;
            r_ext_end  <= n_ext_end;
            r_ext_id   <= n_ext_id;
            r_len_hi   <= n_len_hi;
            r_name_rem <= n_name_rem;
            r_emitted  <= n_emitted;
            r_version  <= n_version;
            r_reason   <= n_reason;
            r_wr_ptr   <= r_wr_ptr + QAW'(push_cnt);
            if (pop) r_rd_ptr <= r_rd_ptr + QAW'(1);
            r_count    <= r_count + (QAW+1)'(push_cnt) - (QAW+1)'(pop);
        end
    end

    assign o_out.valid       = (r_count != '0);
    assign o_out.result_kind = r_queue[r_rd_ptr].result_kind;
    assign o_out.name_char   = r_queue[r_rd_ptr].name_char;
    assign o_out.found       = r_queue[r_rd_ptr].found;
    assign o_out.reason      = r_queue[r_rd_ptr].reason;
    assign o_out.version     = r_queue[r_rd_ptr].version;
    assign o_out.name_length = r_queue[r_rd_ptr].name_length;
    assign o_out.last_of_run = r_queue[r_rd_ptr].last_of_run;

    `TSX_ASSERT_NOW(a_queue_bound, 1'b1, r_count <= (QAW+1)'(QDEPTH),
        "result queue overflow")
    `TSX_ASSERT_NOW(a_verdict_last,
        o_out.valid && o_out.result_kind == tlssni_pkg::KIND_VERDICT,
        o_out.last_of_run, "verdict not last of run")
    `TSX_ASSERT_NOW(a_name_clean,
        o_out.valid && o_out.result_kind == tlssni_pkg::KIND_NAME,
        !o_out.found && o_out.reason == tlssni_pkg::RSN_FOUND && o_out.name_length == 8'd0,
        "name result carries verdict fields")
    `TSX_ASSERT_NOW(a_found_reason,
        o_out.valid && o_out.result_kind == tlssni_pkg::KIND_VERDICT,
        o_out.found == (o_out.reason == tlssni_pkg::RSN_FOUND),
        "found flag disagrees with reason")
    `TSX_ASSERT_NEXT(a_count_track, 1'b1,
        r_count == $past(r_count) + (QAW+1)'($past(push_cnt)) - (QAW+1)'($past(pop)),
        "queue count mismatch")

endmodule
